[rtl/matrix_multiply_engine_top_macros.svh]
// Assertion macros shared by the checker of the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define MME_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mme_pkg.sv]
// Package with shared types and constants of the matrix multiply engine.
`default_nettype none
package mme_pkg;

  // Fixed field widths of the stream and register ports
  localparam int CFG_W      = 4;
  localparam int ROW_W      = 3;
  localparam int ELEM_IN_W  = 16;
  localparam int VALUE_W    = 32;
  localparam int OPS_W      = 11;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int OPS_PER_MAC = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Raw register contents
  typedef struct packed {
    logic [CFG_W-1:0] rows_a;
    logic [CFG_W-1:0] inner_dim;
    logic [CFG_W-1:0] cols_b;
  } cfg_t;

  // Flags that travel with one multiply-add down the pipeline
  typedef struct packed {
    logic first;
    logic last_k;
    logic fin;
  } tag_t;

  // Controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    tag_t             tag;
    logic [OPS_W-1:0] ops;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/matrix_multiply_engine_top.sv]
// Top level of the integer matrix multiply engine.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------
//  apb       | in  | psel/penable/pready     | rows_a, inner_dim, cols_b
//  s_axis    | in  | s_axis_tvalid/tready    | req_type; row, col, element
//  m_axis    | out | m_axis_tvalid/tready    | out_row, out_col, out_value,
//            |     |                         | op_count; last
//
// Write items of A and B are taken while no run is in progress, so loads can stream every cycle.
// A compute item issues one multiply-add a cycle for each result, through the single
// read port of each store, then through the read, multiply and accumulate stages, and
// waits for those stages to drain before the next dot product.
// A stalled result holds the loop before the next dot product starts.
// Reset is synchronous; the element stores are not cleared.
`default_nettype none
module matrix_multiply_engine_top #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mme_pkg::PADDR_W-1:0]    paddr,
  input  logic [mme_pkg::PDATA_W-1:0]    pwdata,
  output logic [mme_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mme_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // row, col, element
  input  logic [mme_pkg::REQ_W-1:0]      s_axis_tuser,   // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mme_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // out_row, out_col, out_value,
                                                         // op_count
  output logic                           m_axis_tlast    // last
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  mme_pkg::cfg_t    cfg;
  mme_pkg::cmd_t    cmd;
  mme_pkg::status_t status;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;

  logic [mme_pkg::ROW_W-1:0]   out_row, out_col;
  logic [mme_pkg::VALUE_W-1:0] out_value;
  logic [mme_pkg::OPS_W-1:0]   op_count;

  mme_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_req   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd),
    .i_idx    (i_idx),
    .j_idx    (j_idx),
    .k_idx    (k_idx)
  );

  mme_dp #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .i_idx     (i_idx),
    .j_idx     (j_idx),
    .k_idx     (k_idx),
    .in_row    (s_axis_tdata[2:0]),
    .in_col    (s_axis_tdata[5:3]),
    .in_elem   (s_axis_tdata[21:6]),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .op_count  (op_count),
    .out_last  (m_axis_tlast)
  );

  // Pack the result item, zero-filled to whole bytes
  assign m_axis_tdata = {7'b0, op_count, out_value, out_col, out_row};

endmodule
`default_nettype wire

[rtl/mme_regs.sv]
// Configuration registers behind the APB port.
`default_nettype none
module mme_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mme_pkg::PADDR_W-1:0] paddr,
  input  logic [mme_pkg::PDATA_W-1:0] pwdata,
  output logic [mme_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output mme_pkg::cfg_t               cfg
);

  logic                 wr_en;
  mme_pkg::reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = mme_pkg::reg_idx_t'(paddr[3:2]);

  // Write the addressed register; addresses past the list drop the item
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_a    <= mme_pkg::CFG_W'(8);
      cfg.inner_dim <= mme_pkg::CFG_W'(8);
      cfg.cols_b    <= mme_pkg::CFG_W'(8);
    end else if (wr_en) begin
      case (idx)
        mme_pkg::REG_ROWS_A:    cfg.rows_a    <= pwdata[mme_pkg::CFG_W-1:0];
        mme_pkg::REG_INNER_DIM: cfg.inner_dim <= pwdata[mme_pkg::CFG_W-1:0];
        mme_pkg::REG_COLS_B:    cfg.cols_b    <= pwdata[mme_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      mme_pkg::REG_ROWS_A:    prdata = mme_pkg::PDATA_W'(cfg.rows_a);
      mme_pkg::REG_INNER_DIM: prdata = mme_pkg::PDATA_W'(cfg.inner_dim);
      mme_pkg::REG_COLS_B:    prdata = mme_pkg::PDATA_W'(cfg.cols_b);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/mme_ctrl.sv]
// Controller that sequences element writes and the multiply-add loops.
`default_nettype none
module mme_ctrl #(
  parameter int MAX_DIM = 8,
  localparam int DIM_W  = $clog2(MAX_DIM + 1),
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mme_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [mme_pkg::REQ_W-1:0] in_req,
  output logic                      in_ready,
  input  mme_pkg::status_t          status,
  output mme_pkg::cmd_t             cmd,
  output logic [IDX_W-1:0]          i_idx,
  output logic [IDX_W-1:0]          j_idx,
  output logic [IDX_W-1:0]          k_idx
);

  mme_pkg::state_t          state, state_next;
  logic [DIM_W-1:0]         i, j, k;
  logic [mme_pkg::OPS_W-1:0] ops;
  logic [DIM_W-1:0]         nr, nc, nk;
  logic [mme_pkg::OPS_W-1:0] ops_calc;
  logic                     k_last, i_last, j_last, elem_last;
  logic                     start, proceed, accept;

  // Treat zero as one and cap at the array size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [mme_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign nr = clamp_dim(cfg.rows_a);
  assign nk = clamp_dim(cfg.inner_dim);
  assign nc = clamp_dim(cfg.cols_b);

  assign ops_calc = mme_pkg::OPS_W'(mme_pkg::OPS_PER_MAC) * mme_pkg::OPS_W'(nr)
                  * mme_pkg::OPS_W'(nc) * mme_pkg::OPS_W'(nk);

  assign k_last    = (k == nk - DIM_W'(1));
  assign i_last    = (i == nr - DIM_W'(1));
  assign j_last    = (j == nc - DIM_W'(1));
  assign elem_last = i_last && j_last;

  assign accept  = in_valid && in_ready;
  assign start   = accept && (in_req == mme_pkg::REQ_COMPUTE);
  assign proceed = !status.busy && status.out_free;

  assign i_idx = i[IDX_W-1:0];
  assign j_idx = j[IDX_W-1:0];
  assign k_idx = k[IDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mme_pkg::ST_IDLE:  if (start) state_next = mme_pkg::ST_ISSUE;
      mme_pkg::ST_ISSUE: if (k_last) state_next = mme_pkg::ST_WAIT;
      mme_pkg::ST_WAIT: begin
        if (proceed) state_next = elem_last ? mme_pkg::ST_IDLE : mme_pkg::ST_ISSUE;
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = (state == mme_pkg::ST_IDLE);
    cmd.wr_a       = accept && (in_req == mme_pkg::REQ_WRITE_A);
    cmd.wr_b       = accept && (in_req == mme_pkg::REQ_WRITE_B);
    cmd.issue      = (state == mme_pkg::ST_ISSUE);
    cmd.tag.first  = (k == '0);
    cmd.tag.last_k = k_last;
    cmd.tag.fin    = k_last && elem_last;
    cmd.ops        = ops;
  end

  // State and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        mme_pkg::ST_IDLE: begin
          if (start) begin
            i <= '0;
            j <= '0;
            k <= '0;
          end
        end
        mme_pkg::ST_ISSUE: begin
          if (!k_last) k <= k + DIM_W'(1);
        end
        mme_pkg::ST_WAIT: begin
          if (proceed && !elem_last) begin
            k <= '0;
            if (j_last) begin
              j <= '0;
              i <= i + DIM_W'(1);
            end else begin
              j <= j + DIM_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the operation count at the start of a run
  always_ff @(posedge clk) begin
    if (start) ops <= ops_calc;
  end

endmodule
`default_nettype wire

[rtl/mme_dp.sv]
// Datapath: element stores, multiplier, accumulator and output register.
`default_nettype none
module mme_dp #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mme_pkg::cmd_t                        cmd,
  input  logic [IDX_W-1:0]                     i_idx,
  input  logic [IDX_W-1:0]                     j_idx,
  input  logic [IDX_W-1:0]                     k_idx,
  input  logic [mme_pkg::ROW_W-1:0]            in_row,
  input  logic [mme_pkg::ROW_W-1:0]            in_col,
  input  logic signed [mme_pkg::ELEM_IN_W-1:0] in_elem,
  output mme_pkg::status_t                     status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mme_pkg::ROW_W-1:0]            out_row,
  output logic [mme_pkg::ROW_W-1:0]            out_col,
  output logic [mme_pkg::VALUE_W-1:0]          out_value,
  output logic [mme_pkg::OPS_W-1:0]            op_count,
  output logic                                 out_last
);

  localparam int EW = ELEMENT_WIDTH;

  logic [EW-1:0]        mem_a [DEPTH];
  logic [EW-1:0]        mem_b [DEPTH];

  logic [ADDR_W-1:0]    wr_addr, a_addr, b_addr;
  logic                 wr_ok;
  logic [EW-1:0]        wr_elem;

  logic                 s1_valid;
  mme_pkg::tag_t        s1_tag;
  logic [IDX_W-1:0]     s1_i, s1_j;
  logic signed [EW-1:0] rd_a, rd_b;

  logic signed [2*EW-1:0] mul;

  logic                       s2_valid;
  mme_pkg::tag_t              s2_tag;
  logic [IDX_W-1:0]           s2_i, s2_j;
  logic [mme_pkg::VALUE_W-1:0] s2_prod;

  logic [mme_pkg::VALUE_W-1:0] acc, acc_sum;

  // Store addresses, row-major
  assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
  assign a_addr  = ADDR_W'(i_idx) * ADDR_W'(MAX_DIM) + ADDR_W'(k_idx);
  assign b_addr  = ADDR_W'(k_idx) * ADDR_W'(MAX_DIM) + ADDR_W'(j_idx);
  assign wr_ok   = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_elem = EW'(in_elem);

  // Store A: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_ok) mem_a[wr_addr] <= wr_elem;
    if (cmd.issue) rd_a <= mem_a[a_addr];
  end

  // Store B: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_b && wr_ok) mem_b[wr_addr] <= wr_elem;
    if (cmd.issue) rd_b <= mem_b[b_addr];
  end

  // Carry the flags and indices alongside the read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_tag <= cmd.tag;
      s1_i   <= i_idx;
      s1_j   <= j_idx;
    end
  end

  // Multiply and register the product
  assign mul = rd_a * rd_b;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_prod <= mme_pkg::VALUE_W'(mul);
      s2_tag  <= s1_tag;
      s2_i    <= s1_i;
      s2_j    <= s1_j;
    end
  end

  // Accumulate, restarting on the first term of each dot product
  assign acc_sum = s2_tag.first ? s2_prod : acc + s2_prod;

  always_ff @(posedge clk) begin
    if (s2_valid) acc <= acc_sum;
  end

  // Load the output register on the last term of a dot product
  always_ff @(posedge clk) begin
    if (s2_valid && s2_tag.last_k) begin
      out_row   <= mme_pkg::ROW_W'(s2_i);
      out_col   <= mme_pkg::ROW_W'(s2_j);
      out_value <= acc_sum;
      op_count  <= s2_tag.fin ? cmd.ops : '0;
      out_last  <= s2_tag.fin;
    end
  end

  // Pipeline and output valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      if (s2_valid && s2_tag.last_k) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.busy     = s1_valid || s2_valid;
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[rtl/mme_checker.sv]
// Port-level checker for the matrix multiply engine and its bind.
`default_nettype none
`include "matrix_multiply_engine_top_macros.svh"
module mme_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [mme_pkg::REQ_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mme_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  // A stalled result holds its payload
  `MME_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // No item is taken while a result is pending
  `MME_ASSERT_SAME(a_no_accept_busy, m_axis_tvalid, !s_axis_tready, "input ready during result")

  // A compute item closes the input until the run ends
  `MME_ASSERT_NEXT(a_compute_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == mme_pkg::REQ_COMPUTE), !s_axis_tready, "input ready after compute")

  // Only the final result carries the operation count
  `MME_ASSERT_SAME(a_ops_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[48:38] == '0, "op count on non-final result")

  // The input opens again once the final result is taken
  `MME_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "input not ready after run")

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[tb/mme_checker.sv]
// Checker for the matrix multiply engine: watches the buses, predicts C and compares results.
`timescale 1ns / 1ps
module mme_scoreboard (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mme_pkg::PADDR_W-1:0]    paddr,
  input  logic [mme_pkg::PDATA_W-1:0]    pwdata,
  input  logic                           pready,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [mme_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // row, col, element
  input  logic [mme_pkg::REQ_W-1:0]      s_axis_tuser,   // req_type
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [mme_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // out_row, out_col, out_value,
                                                         // op_count
  input  logic                           m_axis_tlast,   // last
  output int                             mismatches,
  output int                             outstanding
);

  localparam int DIM = 8;

  // One expected element of C
  typedef struct packed {
    logic [mme_pkg::ROW_W-1:0]   row;
    logic [mme_pkg::ROW_W-1:0]   col;
    logic [mme_pkg::VALUE_W-1:0] value;
    logic [mme_pkg::OPS_W-1:0]   ops;
    logic                        last;
  } c_elem_t;

  c_elem_t                              pending_c [$];
  logic signed [mme_pkg::ELEM_IN_W-1:0] a_store [0:DIM*DIM-1];
  logic signed [mme_pkg::ELEM_IN_W-1:0] b_store [0:DIM*DIM-1];
  logic [mme_pkg::CFG_W-1:0]            rows_a_reg;
  logic [mme_pkg::CFG_W-1:0]            inner_dim_reg;
  logic [mme_pkg::CFG_W-1:0]            cols_b_reg;

  initial mismatches = 0;

  // A register value of zero acts as one, anything above the store size as the size
  function automatic int dim_of(input logic [mme_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what, input logic [mme_pkg::VALUE_W-1:0] got,
                                 input logic [mme_pkg::VALUE_W-1:0] want,
                                 input c_elem_t ref_e);
    $display("%0t ns: C[%0d][%0d] %s: got 0x%0h, expected 0x%0h",
             $time, ref_e.row, ref_e.col, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // Queue every element of C, row-major, as the stores stand now
  task automatic predict_product();
    int      nr;
    int      nk;
    int      nc;
    int      acc;
    c_elem_t e;
    nr = dim_of(rows_a_reg);
    nk = dim_of(inner_dim_reg);
    nc = dim_of(cols_b_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += int'(a_store[i*DIM+k]) * int'(b_store[k*DIM+j]);
        end
        e.row   = mme_pkg::ROW_W'(i);
        e.col   = mme_pkg::ROW_W'(j);
        e.value = acc;
        e.last  = (i == nr - 1) && (j == nc - 1);
        e.ops   = e.last ? mme_pkg::OPS_W'(mme_pkg::OPS_PER_MAC * nr * nc * nk) : '0;
        pending_c.push_back(e);
      end
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    c_elem_t got;
    c_elem_t want;
    got.row   = m_axis_tdata[2:0];
    got.col   = m_axis_tdata[5:3];
    got.value = m_axis_tdata[37:6];
    got.ops   = m_axis_tdata[48:38];
    got.last  = m_axis_tlast;
    if (pending_c.size() == 0) begin
      report_mismatch("result with none expected", got.value, '0, got);
      return;
    end
    want = pending_c.pop_front();
    if (got.row != want.row)
      report_mismatch("out_row", mme_pkg::VALUE_W'(got.row), mme_pkg::VALUE_W'(want.row), want);
    if (got.col != want.col)
      report_mismatch("out_col", mme_pkg::VALUE_W'(got.col), mme_pkg::VALUE_W'(want.col), want);
    if (got.value != want.value)
      report_mismatch("out_value", got.value, want.value, want);
    if (got.ops != want.ops)
      report_mismatch("op_count", mme_pkg::VALUE_W'(got.ops), mme_pkg::VALUE_W'(want.ops), want);
    if (got.last != want.last)
      report_mismatch("last", mme_pkg::VALUE_W'(got.last), mme_pkg::VALUE_W'(want.last), want);
  endtask

  // Track registers and stores, predict on compute, check on results
  always @(posedge clk) begin
    if (rst) begin
      pending_c.delete();
      rows_a_reg    = 4'd8;
      inner_dim_reg = 4'd8;
      cols_b_reg    = 4'd8;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mme_pkg::REG_ROWS_A:    rows_a_reg    = pwdata[mme_pkg::CFG_W-1:0];
          mme_pkg::REG_INNER_DIM: inner_dim_reg = pwdata[mme_pkg::CFG_W-1:0];
          mme_pkg::REG_COLS_B:    cols_b_reg    = pwdata[mme_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        // Store row-major: row in the upper index bits, column in the lower
        case (s_axis_tuser)
          mme_pkg::REQ_WRITE_A:
            a_store[{s_axis_tdata[2:0], s_axis_tdata[5:3]}] = s_axis_tdata[21:6];
          mme_pkg::REQ_WRITE_B:
            b_store[{s_axis_tdata[2:0], s_axis_tdata[5:3]}] = s_axis_tdata[21:6];
          mme_pkg::REQ_COMPUTE: predict_product();
          default: ;
        endcase
      end
    end
    outstanding <= pending_c.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for the matrix multiply engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int                        DIM            = 8;
  localparam int                        ITEM_TARGET    = 370;
  localparam int                        PHASES         = 8;
  localparam int                        SETTLE_CYCLES  = 30;
  localparam int                        HOLD_CYCLES    = 300;
  localparam int                        WATCHDOG_LIMIT = 4000;
  localparam logic [mme_pkg::REQ_W-1:0] REQ_UNUSED     = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [mme_pkg::PADDR_W-1:0]    paddr = '0;
  logic [mme_pkg::PDATA_W-1:0]    pwdata = '0;
  logic [mme_pkg::PDATA_W-1:0]    prdata;
  logic                           pready;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mme_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // row, col, element
  logic [mme_pkg::REQ_W-1:0]      s_axis_tuser = '0;   // req_type
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mme_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // out_row, out_col, out_value, op_count
  logic                           m_axis_tlast;        // last
  int                             mismatches;
  int                             outstanding;

  // Stimulus-side view of the block
  logic [mme_pkg::CFG_W-1:0] dims [0:2];
  logic [DIM*DIM-1:0]        a_written = '0;
  logic [DIM*DIM-1:0]        b_written = '0;
  int                        item_count = 0;
  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        hold_seq = 0;
  int                        hold_seen = 0;
  int                        hold_left = 0;
  int                        quiet_cycles = 0;

  matrix_multiply_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  mme_scoreboard scoreboard (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int dim_of(input logic [mme_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Random values half the time, otherwise the extremes or small values
  function automatic logic [mme_pkg::ELEM_IN_W-1:0] pick_element();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      4:       return mme_pkg::ELEM_IN_W'($urandom_range(3));
      default: return mme_pkg::ELEM_IN_W'($urandom);
    endcase
  endfunction

  // Offer one item, idling first when the sender idles, and wait for acceptance
  task automatic send_item(input logic [mme_pkg::REQ_W-1:0] req,
                           input logic [mme_pkg::ROW_W-1:0] row,
                           input logic [mme_pkg::ROW_W-1:0] col,
                           input logic [mme_pkg::ELEM_IN_W-1:0] elem);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, elem, col, row};
    do @(posedge clk); while (!s_axis_tready);
    if (req == mme_pkg::REQ_WRITE_A) a_written[{row, col}] = 1'b1;
    if (req == mme_pkg::REQ_WRITE_B) b_written[{row, col}] = 1'b1;
    if (req != REQ_UNUSED) item_count++;
  endtask

  task automatic write_random();
    send_item($urandom_range(1) ? mme_pkg::REQ_WRITE_B : mme_pkg::REQ_WRITE_A,
              mme_pkg::ROW_W'($urandom), mme_pkg::ROW_W'($urandom), pick_element());
  endtask

  // Load every entry the next product reads that was never written, then start it
  task automatic start_product();
    for (int i = 0; i < dim_of(dims[mme_pkg::REG_ROWS_A]); i++) begin
      for (int k = 0; k < dim_of(dims[mme_pkg::REG_INNER_DIM]); k++) begin
        if (!a_written[i*DIM+k])
          send_item(mme_pkg::REQ_WRITE_A, mme_pkg::ROW_W'(i), mme_pkg::ROW_W'(k),
                    pick_element());
      end
    end
    for (int k = 0; k < dim_of(dims[mme_pkg::REG_INNER_DIM]); k++) begin
      for (int j = 0; j < dim_of(dims[mme_pkg::REG_COLS_B]); j++) begin
        if (!b_written[k*DIM+j])
          send_item(mme_pkg::REQ_WRITE_B, mme_pkg::ROW_W'(k), mme_pkg::ROW_W'(j),
                    pick_element());
      end
    end
    send_item(mme_pkg::REQ_COMPUTE, mme_pkg::ROW_W'($urandom), mme_pkg::ROW_W'($urandom),
              mme_pkg::ELEM_IN_W'($urandom));
  endtask

  // Hold the stream until every expected result has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input mme_pkg::reg_idx_t idx,
                           input logic [mme_pkg::CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= mme_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    dims[idx] = val;
    @(posedge clk);
  endtask

  // Reconfigure only once the block has gone quiet
  task automatic set_dims(input logic [mme_pkg::CFG_W-1:0] nr,
                          input logic [mme_pkg::CFG_W-1:0] nk,
                          input logic [mme_pkg::CFG_W-1:0] nc);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(mme_pkg::REG_ROWS_A, nr);
    apb_write(mme_pkg::REG_INNER_DIM, nk);
    apb_write(mme_pkg::REG_COLS_B, nc);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SEND) ? 49 : (mode == IDLE_BOTH) ? 27 : 0;
    stall_pct    <= (mode == IDLE_RECV) ? 49 : (mode == IDLE_BOTH) ? 27 : 0;
  endtask

  initial begin
    int phase_end;
    int burst;
    dims[mme_pkg::REG_ROWS_A]    = 4'd8;
    dims[mme_pkg::REG_INNER_DIM] = 4'd8;
    dims[mme_pkg::REG_COLS_B]    = 4'd8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-term products at the extremes
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 16'h8000);
    send_item(mme_pkg::REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
    start_product();
    send_item(mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 16'h7fff);
    start_product();
    send_item(REQ_UNUSED, 3'd7, 3'd7, 16'hffff);
    // Zero dimension registers act as one; the sum takes two large terms of opposite sign
    set_dims(4'd0, 4'd2, 4'd0);
    send_item(mme_pkg::REQ_WRITE_A, 3'd0, 3'd1, 16'h8000);
    send_item(mme_pkg::REQ_WRITE_B, 3'd1, 3'd0, 16'h8000);
    start_product();
    send_item(mme_pkg::REQ_WRITE_A, 3'd7, 3'd7, 16'h7fff);
    send_item(mme_pkg::REQ_WRITE_B, 3'd7, 3'd7, 16'hffff);
    send_item(mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 16'h0000);
    start_product();

    // Random phases over several shapes and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_dims(4'd2, 4'd3, 4'd2);
        1:       set_dims(4'd15, 4'd0, 4'd4);
        2:       set_dims(4'd1, 4'd8, 4'd1);
        3:       set_dims(4'd8, 4'd1, 4'd8);
        4:       set_dims(4'd4, 4'd4, 4'd3);
        5:       set_dims(4'd0, 4'd15, 4'd15);
        6:       set_dims(4'd8, 4'd8, 4'd8);
        default: set_dims(mme_pkg::CFG_W'($urandom), mme_pkg::CFG_W'($urandom),
                          mme_pkg::CFG_W'($urandom));
      endcase
      set_idle(idle_mode_t'(p % 4));
      phase_end = item_count + (ITEM_TARGET - item_count) / (PHASES - p);

      // Stall the result side while items keep coming, so the block backs up
      if (p == 6) begin
        hold_seq <= hold_seq + 1;
        start_product();
        repeat (4) write_random();
        start_product();
      end

      while (item_count < phase_end) begin
        burst = $urandom_range(6);
        repeat (burst) begin
          if ($urandom_range(9) == 0)
            send_item(REQ_UNUSED, mme_pkg::ROW_W'($urandom), mme_pkg::ROW_W'($urandom),
                      mme_pkg::ELEM_IN_W'($urandom));
          write_random();
        end
        start_product();
        if ($urandom_range(7) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[matrix_multiply_engine_top.f]
+incdir+rtl
rtl/mme_pkg.sv
rtl/mme_regs.sv
rtl/mme_ctrl.sv
rtl/mme_dp.sv
rtl/matrix_multiply_engine_top.sv
rtl/mme_checker.sv
tb/mme_checker.sv
tb/tb.sv
